>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every rising edge outside reset.
`define OSF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("osf assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define OSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("osf assertion failed");

`else

`define OSF_ASSERT(lbl, clk, rst_n, prop)
`define OSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/osf_pkg.sv
// ----------------------------------------------------------------------------
// osf_pkg
// Shared constants, types and the reciprocal table of the outlier filter.
// ----------------------------------------------------------------------------
package osf_pkg;

    // sizing
    localparam int NUM_SENSORS = 10;
    localparam int WINDOW      = 5;
    localparam int HIST_DEPTH  = NUM_SENSORS * WINDOW;

    // field widths
    localparam int ID_W       = 4;
    localparam int SAMPLE_W   = 16;
    localparam int TS_W       = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // derived widths
    localparam int SID_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int POS_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int ADDR_W = $clog2(HIST_DEPTH);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int DIV_W  = 3;
    localparam int RECIP_K = SUM_W + DIV_W;
    localparam int PROD_W  = SUM_W + RECIP_K;

    // status codes
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MEAN    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_LIMIT = 2'd2;

    // register reset values
    localparam logic [SAMPLE_W-1:0] MIN_VALID_RST     = 16'h9C00;
    localparam logic [SAMPLE_W-1:0] MAX_VALID_RST     = 16'h6400;
    localparam logic [SAMPLE_W-1:0] OUTLIER_LIMIT_RST = 16'h3200;

    // -1.0 in Q8.8
    localparam logic [SAMPLE_W-1:0] INVALID_VALUE = 16'hFF00;

    localparam longint unsigned RECIP_ONE = longint'(1) << RECIP_K;

    typedef struct packed {
        logic             go;
        logic [SUM_W-1:0] mag;
        logic [CNT_W-1:0] cnt;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quot;
    } div_rsp_t;

    // ceil(2^RECIP_K / d) for the divisors the filter uses
    function automatic logic [RECIP_K-1:0] recip(input logic [DIV_W-1:0] d);
        logic [RECIP_K-1:0] r;
        case (d)
            3'd2:    r = RECIP_K'((RECIP_ONE + 1) / 2);
            3'd3:    r = RECIP_K'((RECIP_ONE + 2) / 3);
            3'd4:    r = RECIP_K'((RECIP_ONE + 3) / 4);
            3'd5:    r = RECIP_K'((RECIP_ONE + 4) / 5);
            3'd6:    r = RECIP_K'((RECIP_ONE + 5) / 6);
            3'd7:    r = RECIP_K'((RECIP_ONE + 6) / 7);
            default: r = '1;
        endcase
        return r;
    endfunction

endpackage

>>> sv/osf_ram.sv
// ----------------------------------------------------------------------------
// osf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module osf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 50,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/osf_div.sv
// ----------------------------------------------------------------------------
// osf_div
// Two-stage divide of a magnitude by a small count via reciprocal multiply.
// ----------------------------------------------------------------------------
module osf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  osf_pkg::div_req_t req,
    output osf_pkg::div_rsp_t rsp
);
    import osf_pkg::*;

    localparam int CHK_W = SUM_W + DIV_W + 1;

    logic              s1_reg;
    logic              done_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  mag_reg;
    logic [DIV_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  quot_reg;

    logic [SUM_W-1:0]        q_est;
    logic signed [CHK_W-1:0] rem;
    logic [SUM_W-1:0]        quot_next;

    // stage 2: estimate, then nudge by one if the remainder is off
    always_comb
    begin
        q_est = prod_reg[RECIP_K +: SUM_W];
        rem   = $signed({1'b0, (CHK_W-1)'(mag_reg)}) -
                $signed(CHK_W'(CHK_W'(q_est) * CHK_W'(cnt_reg)));
        if (rem < 0)
        begin
            quot_next = q_est - SUM_W'(1);
        end
        else if (rem >= $signed(CHK_W'(cnt_reg)))
        begin
            quot_next = q_est + SUM_W'(1);
        end
        else
        begin
            quot_next = q_est;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= req.go;
            done_reg <= s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            prod_reg <= PROD_W'(req.mag) * PROD_W'(recip(DIV_W'(req.cnt)));
            mag_reg  <= req.mag;
            cnt_reg  <= DIV_W'(req.cnt);
        end
        if (s1_reg)
        begin
            quot_reg <= quot_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> sv/multi_sensor_outlier_filter_unit.sv
// ----------------------------------------------------------------------------
// multi_sensor_outlier_filter_unit
// Per-sensor moving average with outlier replacement, one reading at a time.
// ----------------------------------------------------------------------------
// Each beat on the input carries one sensor reading (sensor_idx, Q8.8 sample,
// timestamp) and yields exactly one beat on the output (filtered_value,
// status). A reading with an out-of-range sensor_idx, a sample outside
// [min_valid, max_valid] or a zero timestamp returns -1.0 with status 3 and
// leaves the history untouched. A good reading is written into the sensor's
// ring of WINDOW entries; with fewer than two entries it passes through
// (status 0), otherwise it is compared against the truncated mean of the
// filled entries and replaced by that mean (status 2) when it deviates by
// more than outlier_limit, else passed (status 1). The block handles one
// reading at a time: in_ready is high only while the sequencer idles. The
// time a full reading takes is set by the summation loop, which reads the
// entries one per cycle through the single read port of the history RAM,
// plus the two-stage reciprocal divider. The output is held in its own
// register, so the next reading can be accepted while a result waits for
// out_ready. No clearing pass is needed after reset: the fill count guards
// every entry that is ever read. Configuration writes take effect at once
// and are meant for idle periods.
// ----------------------------------------------------------------------------
module multi_sensor_outlier_filter_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // reading in
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [osf_pkg::ID_W-1:0]              sensor_idx,
    input  logic signed [osf_pkg::SAMPLE_W-1:0]   sample,
    input  logic [osf_pkg::TS_W-1:0]              timestamp,
    // result out
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [osf_pkg::SAMPLE_W-1:0]   filtered_value,
    output logic [osf_pkg::STATUS_W-1:0]          status,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [osf_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [osf_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import osf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SUM,
        S_DIV,
        S_DECIDE,
        S_EMIT
    } state_t;

    localparam logic [ID_W:0]       SENSOR_LIMIT = (ID_W + 1)'(NUM_SENSORS);
    localparam logic [CNT_W-1:0]    WINDOW_CNT   = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0]    CNT_TWO      = CNT_W'(2);
    localparam logic [POS_W-1:0]    POS_LAST     = POS_W'(WINDOW - 1);
    localparam int                  DEV_W        = SAMPLE_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_VALID_RST;
            max_reg <= MAX_VALID_RST;
            lim_reg <= OUTLIER_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_MIN_VALID:     min_reg <= cfg_wdata;
                CFG_MAX_VALID:     max_reg <= cfg_wdata;
                CFG_OUTLIER_LIMIT: lim_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    state_t                     state_reg,     state_next;
    logic [SID_W-1:0]           id_reg,        id_next;
    logic signed [SAMPLE_W-1:0] sample_reg,    sample_next;
    logic [ADDR_W-1:0]          base_reg,      base_next;
    logic [CNT_W-1:0]           cnt_reg,       cnt_next;
    logic [CNT_W-1:0]           k_reg,         k_next;
    logic                       pend_reg,      pend_next;
    logic signed [SUM_W-1:0]    sum_reg,       sum_next;
    logic                       div_go_reg,    div_go_next;
    logic signed [SAMPLE_W-1:0] mean_reg,      mean_next;
    logic [SAMPLE_W-1:0]        res_val_reg,   res_val_next;
    logic [STATUS_W-1:0]        res_st_reg,    res_st_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        out_val_reg,   out_val_next;
    logic [STATUS_W-1:0]        out_st_reg,    out_st_next;

    // per-sensor ring pointers and fill counts
    logic [POS_W-1:0] wpos_reg [NUM_SENSORS];
    logic [CNT_W-1:0] fill_reg [NUM_SENSORS];

    // history RAM ports
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [SAMPLE_W-1:0] ram_rd_data;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                    in_beat;
    logic                    reading_ok;
    logic [POS_W-1:0]        cur_pos;
    logic [CNT_W-1:0]        cur_cnt;
    logic [POS_W-1:0]        new_pos;
    logic [CNT_W-1:0]        new_cnt;
    logic signed [DEV_W-1:0] dev;
    logic [DEV_W-1:0]        dev_abs;
    logic [SUM_W-1:0]        sum_abs;
    logic signed [SAMPLE_W-1:0] quot_signed;

    assign in_ready = (state_reg == S_IDLE);
    assign in_beat  = in_valid && in_ready;

    // reject bad id, out-of-bounds sample or a zero timestamp
    assign reading_ok = ({1'b0, sensor_idx} < SENSOR_LIMIT) &&
                        (sample >= $signed(min_reg)) &&
                        (sample <= $signed(max_reg)) &&
                        (timestamp != '0);

    // ring bookkeeping for the sensor held in id_reg
    assign cur_pos = wpos_reg[id_reg];
    assign cur_cnt = fill_reg[id_reg];
    assign new_pos = (cur_pos >= POS_LAST) ? '0 : cur_pos + POS_W'(1);
    assign new_cnt = (cur_cnt < WINDOW_CNT) ? cur_cnt + CNT_W'(1) : WINDOW_CNT;

    // write the new sample at the ring slot, read entries back during the sum
    assign ram_wr_en   = (state_reg == S_WRITE);
    assign ram_wr_addr = base_reg + ADDR_W'(cur_pos);
    assign ram_rd_en   = (state_reg == S_SUM) && (k_reg != cnt_reg);
    assign ram_rd_addr = base_reg + ADDR_W'(k_reg);

    // divider works on the magnitude; the sign is put back afterwards
    assign sum_abs      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_req.go   = div_go_reg;
    assign div_req.mag  = sum_abs;
    assign div_req.cnt  = cnt_reg;
    assign quot_signed  = sum_reg[SUM_W-1] ? -$signed(SAMPLE_W'(div_rsp.quot))
                                           : $signed(SAMPLE_W'(div_rsp.quot));

    // deviation from the mean, exact in one extra bit
    assign dev     = $signed({sample_reg[SAMPLE_W-1], sample_reg}) -
                     $signed({mean_reg[SAMPLE_W-1], mean_reg});
    assign dev_abs = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);

    always_comb
    begin
        state_next     = state_reg;
        id_next        = id_reg;
        sample_next    = sample_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        sum_next       = sum_reg;
        div_go_next    = 1'b0;
        mean_next      = mean_reg;
        res_val_next   = res_val_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;

        // drop the output beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    id_next     = SID_W'(sensor_idx);
                    sample_next = sample;
                    base_next   = ADDR_W'(int'(SID_W'(sensor_idx)) * WINDOW);
                    if (reading_ok)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        res_val_next = INVALID_VALUE;
                        res_st_next  = ST_INVALID;
                        state_next   = S_EMIT;
                    end
                end
            end

            S_WRITE:
            begin
                cnt_next = new_cnt;
                if (new_cnt < CNT_TWO)
                begin
                    res_val_next = sample_reg;
                    res_st_next  = ST_SHORT;
                    state_next   = S_EMIT;
                end
                else
                begin
                    k_next     = '0;
                    pend_next  = 1'b0;
                    sum_next   = '0;
                    state_next = S_SUM;
                end
            end

            S_SUM:
            begin
                // accumulate the entry read last cycle, issue the next read
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'($signed(ram_rd_data));
                end
                pend_next = ram_rd_en;
                if (ram_rd_en)
                begin
                    k_next = k_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    div_go_next = 1'b1;
                    state_next  = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    mean_next  = quot_signed;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (dev_abs > {1'b0, lim_reg})
                begin
                    res_val_next = mean_reg;
                    res_st_next  = ST_MEAN;
                end
                else
                begin
                    res_val_next = sample_reg;
                    res_st_next  = ST_ACCEPT;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_val_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            div_go_reg    <= div_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        sample_reg  <= sample_next;
        base_reg    <= base_next;
        cnt_reg     <= cnt_next;
        k_reg       <= k_next;
        sum_reg     <= sum_next;
        mean_reg    <= mean_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

    // advance the ring pointer and fill count of the sensor being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SENSORS; s++)
            begin
                wpos_reg[s] <= '0;
                fill_reg[s] <= '0;
            end
        end
        else if (state_reg == S_WRITE)
        begin
            wpos_reg[id_reg] <= new_pos;
            fill_reg[id_reg] <= new_cnt;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = out_val_reg;
    assign status         = out_st_reg;

    // ------------------------------------------------------------------
    // History store and divider
    // ------------------------------------------------------------------
    osf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (sample_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    osf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `OSF_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)
    `OSF_ASSERT(a_invalid_value, clk, rst_n, !(out_valid && status == ST_INVALID) || filtered_value == $signed(INVALID_VALUE))
    `OSF_ASSERT(a_sum_count, clk, rst_n, (state_reg != S_SUM) || (cnt_reg >= CNT_TWO && cnt_reg <= WINDOW_CNT))
    `OSF_ASSERT(a_div_done_in_div, clk, rst_n, !div_rsp.done || state_reg == S_DIV)

endmodule
